>>> src/cmt_pkg.sv
`timescale 1ns / 1ps
package cmt_pkg;

  localparam int LBA_BITS          = 16;
  localparam int PPA_BITS          = 24;
  localparam int SLOT_OUT_BITS     = 6;
  localparam int CACHE_ENTRIES_DEF = 64;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TRIM  = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LBA_BITS-1:0] lba;
    logic [PPA_BITS-1:0] new_ppa;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_OUT_BITS-1:0] slot;
    logic [PPA_BITS-1:0]      old_ppa;
    logic                     old_present;
    logic                     writeback;
    logic [LBA_BITS-1:0]      writeback_lba;
    logic [PPA_BITS-1:0]      writeback_ppa;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic hit_read;
    logic hit_done;
    logic miss_read;
    logic miss_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic match;
    logic scan_last;
  } sts_t;

endpackage

>>> src/cmt_ctrl.sv
`timescale 1ns / 1ps
module cmt_ctrl
  import cmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_HRD   = 3'd3;
  localparam logic [2:0] S_HFIN  = 3'd4;
  localparam logic [2:0] S_MRD   = 3'd5;
  localparam logic [2:0] S_MFIN  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) state_d = S_HRD;
        else if (sts_i.scan_last) state_d = S_MRD;
      end
      S_HRD: begin
        cmd_o.hit_read = 1'b1;
        state_d        = S_HFIN;
      end
      S_HFIN: begin
        cmd_o.hit_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_MRD: begin
        cmd_o.miss_read = 1'b1;
        state_d         = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.miss_done = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

endmodule

>>> src/cmt_datapath.sv
`timescale 1ns / 1ps
module cmt_datapath
  import cmt_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output sts_t sts_o,
  output rsp_t rsp_o,
  output logic result_valid_o
);

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int MAP_DEPTH = 1 << LBA_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

  logic [LBA_BITS-1:0] lba_mem [CACHE_ENTRIES];
  logic [PPA_BITS-1:0] ppa_mem [CACHE_ENTRIES];
  logic [PPA_BITS-1:0] map_mem [MAP_DEPTH];

  logic [CACHE_ENTRIES-1:0] valid_q, dirty_q;
  logic [IW-1:0]       rd_idx_q, slot_q, fifo_q;
  logic [LBA_BITS-1:0] clr_idx_q;
  req_t                req_q;
  logic [LBA_BITS-1:0] lba_rd_q;
  logic [PPA_BITS-1:0] ppa_rd_q, map_rd_q;
  rsp_t                rsp_q;
  logic                done_q;

  logic [IW-1:0] lba_raddr, ppa_raddr, fifo_next;
  logic          victim_wb;
  logic          is_write;

  assign is_write  = (req_q.kind == KIND_WRITE);
  assign fifo_next = (fifo_q == LAST_IDX) ? '0 : fifo_q + IW'(1);
  assign victim_wb = valid_q[fifo_q] & dirty_q[fifo_q];

  assign sts_o.clear_last = &clr_idx_q;
  assign sts_o.match      = valid_q[rd_idx_q] && (lba_rd_q == req_q.lba);
  assign sts_o.scan_last  = (rd_idx_q == LAST_IDX);

  always_comb begin
    lba_raddr = rd_idx_q + IW'(1);
    if (cmd_i.accept) lba_raddr = '0;
    else if (cmd_i.miss_read) lba_raddr = fifo_q;
    ppa_raddr = cmd_i.miss_read ? fifo_q : slot_q;
  end

  // cache tag store
  always_ff @(posedge clk_i) begin
    if (cmd_i.miss_done) lba_mem[fifo_q] <= req_q.lba;
    lba_rd_q <= lba_mem[lba_raddr];
  end

  // cache mapping store
  always_ff @(posedge clk_i) begin
    if (cmd_i.miss_done) ppa_mem[fifo_q] <= is_write ? req_q.new_ppa : map_rd_q;
    else if (cmd_i.hit_done && is_write) ppa_mem[slot_q] <= req_q.new_ppa;
    ppa_rd_q <= ppa_mem[ppa_raddr];
  end

  // full map, swept to all ones after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) map_mem[clr_idx_q] <= '1;
    else if (cmd_i.miss_done && victim_wb) map_mem[lba_rd_q] <= ppa_rd_q;
    map_rd_q <= map_mem[req_q.lba];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
    if (cmd_i.scan && sts_o.match) slot_q <= rd_idx_q;
    rsp_q.writeback_lba <= '0;
    rsp_q.writeback_ppa <= '0;
    rsp_q.writeback     <= 1'b0;
    if (cmd_i.hit_done) begin
      rsp_q.hit         <= 1'b1;
      rsp_q.slot        <= SLOT_OUT_BITS'(slot_q);
      rsp_q.old_ppa     <= ppa_rd_q;
      rsp_q.old_present <= (ppa_rd_q != '1);
    end else if (cmd_i.miss_done) begin
      rsp_q.hit         <= 1'b0;
      rsp_q.slot        <= SLOT_OUT_BITS'(fifo_q);
      rsp_q.old_ppa     <= map_rd_q;
      rsp_q.old_present <= (map_rd_q != '1);
      rsp_q.writeback   <= victim_wb;
      if (victim_wb) begin
        rsp_q.writeback_lba <= lba_rd_q;
        rsp_q.writeback_ppa <= ppa_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      dirty_q   <= '0;
      rd_idx_q  <= '0;
      fifo_q    <= '0;
      clr_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.hit_done | cmd_i.miss_done;
      if (cmd_i.clear) clr_idx_q <= clr_idx_q + LBA_BITS'(1);
      if (cmd_i.accept) rd_idx_q <= '0;
      else if (cmd_i.scan) rd_idx_q <= rd_idx_q + IW'(1);
      if (cmd_i.hit_done && is_write) dirty_q[slot_q] <= 1'b1;
      if (cmd_i.miss_done) begin
        valid_q[fifo_q] <= 1'b1;
        dirty_q[fifo_q] <= is_write;
        fifo_q          <= fifo_next;
      end
    end
  end

  assign rsp_o          = rsp_q;
  assign result_valid_o = done_q;

endmodule

>>> src/cached_mapping_table_fifo_core.sv
`timescale 1ns / 1ps
// Mapping cache for flash translation: each read, write or trim is looked up by
// a scan of the tag store, one slot per cycle, then finished with a memory read
// and update. A hit stops the scan at its slot, a miss scans every slot. After
// reset all 65536 entries of the full map are swept to all ones, one entry a
// cycle, with busy high. The result is shown on rsp_o for one cycle under
// result_valid_o and cannot be stalled; busy drops the same cycle, so the next
// start can be taken right away.
module cached_mapping_table_fifo_core
  import cmt_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic result_valid_o
);

  cmd_t cmd;
  sts_t sts;

  cmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  cmt_datapath #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i),
    .sts_o         (sts),
    .rsp_o         (rsp_o),
    .result_valid_o(result_valid_o)
  );

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result right after accept");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.hit) |-> !rsp_o.writeback)
    else $error("writeback on hit");

  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.writeback) |->
      (rsp_o.writeback_lba == '0 && rsp_o.writeback_ppa == '0))
    else $error("writeback fields not zero");

endmodule
